@@ src/uart_8n1_bit_timed_transceiver_macros.svh @@
// Assertion macros for the 8N1 transceiver.
// Define NO_ASSERTIONS to compile them out.
`ifndef UART_8N1_BIT_TIMED_TRANSCEIVER_MACROS_SVH
`define UART_8N1_BIT_TIMED_TRANSCEIVER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define UART_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define UART_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UART_ASSERT(lbl, prop, msg)

`define UART_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ src/uart8n1_pkg.sv @@
package uart8n1_pkg;

    localparam int unsigned DATA_BITS = 8;
    localparam int unsigned BYTE_W    = 8;

    localparam int unsigned BIT_TICKS_W  = 16;
    localparam int unsigned TIMEOUT_W    = 32;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned CFG_INDEX_W  = 2;
    localparam int unsigned TX_PHASE_W   = 4;
    localparam int unsigned RX_BIT_W     = 4;

    localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RST  = 16'd52;
    localparam logic [TIMEOUT_W-1:0]   RX_TIMEOUT_RST = 32'd1000;

    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_TICKS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RX_TIMEOUT = 2'd1;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SEND = 2'd1;
    localparam logic [1:0] CMD_ARM  = 2'd2;

    localparam logic [1:0] RX_STATUS_OK      = 2'd0;
    localparam logic [1:0] RX_STATUS_FRAME   = 2'd1;
    localparam logic [1:0] RX_STATUS_TIMEOUT = 2'd2;

    localparam logic [TX_PHASE_W-1:0] TX_IDLE       = 4'd0;
    localparam logic [TX_PHASE_W-1:0] TX_START      = 4'd1;
    localparam logic [TX_PHASE_W-1:0] TX_FIRST_DATA = 4'd2;
    localparam logic [TX_PHASE_W-1:0] TX_LAST_DATA  = TX_PHASE_W'(DATA_BITS + 1);
    localparam logic [TX_PHASE_W-1:0] TX_STOP       = TX_PHASE_W'(DATA_BITS + 2);

endpackage

@@ src/uart_8n1_bit_timed_transceiver.sv @@
// Chan | Handshake            | Fields
// in   | in_valid, in_stall   | command, tx_byte, rx_level
// out  | out_valid, out_stall | tx_line, tx_active, rx_valid, rx_byte, rx_status, busy_res
// cfg  | cfg_we               | cfg_index, cfg_data
//
// One tick per cycle while in_stall is low; the result is registered and shown in the cycle after acceptance.
// Each tick updates the tx/rx counters in one pass of logic ahead of the output register.
// Input stalls only while a result is held and out_stall is high.
// Reset: line idle high, both engines idle, bit_ticks 52, rx timeout 1000.
`include "uart_8n1_bit_timed_transceiver_macros.svh"

module uart_8n1_bit_timed_transceiver
(
    input  logic                                     clk,
    input  logic                                     rst_n,

    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [1:0]                               command,
    input  logic [uart8n1_pkg::BYTE_W-1:0]           tx_byte,
    input  logic                                     rx_level,

    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic                                     tx_line,
    output logic                                     tx_active,
    output logic                                     rx_valid,
    output logic [uart8n1_pkg::BYTE_W-1:0]           rx_byte,
    output logic [1:0]                               rx_status,
    output logic                                     busy_res,

    input  logic                                     cfg_we,
    input  logic [uart8n1_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [uart8n1_pkg::CFG_DATA_W-1:0]       cfg_data
);

    typedef enum logic [1:0]
    {
        RX_IDLE,
        RX_WAIT,
        RX_HALF,
        RX_SAMPLE
    } rx_phase_t;

    logic [uart8n1_pkg::BIT_TICKS_W-1:0] bit_ticks_reg;
    logic [uart8n1_pkg::TIMEOUT_W-1:0]   rx_timeout_reg;

    logic [uart8n1_pkg::BYTE_W-1:0]      tx_shift_reg, tx_shift_next;
    logic [uart8n1_pkg::TX_PHASE_W-1:0]  tx_phase_reg, tx_phase_next;
    logic [uart8n1_pkg::BIT_TICKS_W-1:0] tx_cnt_reg, tx_cnt_next;
    rx_phase_t                           rx_phase_reg, rx_phase_next;
    logic [uart8n1_pkg::BYTE_W-1:0]      rx_shift_reg, rx_shift_next;
    logic [uart8n1_pkg::RX_BIT_W-1:0]    rx_bit_reg, rx_bit_next;
    logic [uart8n1_pkg::BIT_TICKS_W-1:0] rx_cnt_reg, rx_cnt_next;
    logic [uart8n1_pkg::TIMEOUT_W-1:0]   wait_cnt_reg, wait_cnt_next;

    logic                                out_valid_reg, out_valid_next;
    logic                                tx_line_reg, tx_line_next;
    logic                                tx_active_reg, tx_active_next;
    logic                                rx_valid_reg, rx_valid_next;
    logic [uart8n1_pkg::BYTE_W-1:0]      rx_byte_reg, rx_byte_next;
    logic [1:0]                          rx_status_reg, rx_status_next;
    logic                                busy_reg, busy_next;

    logic                                in_fire;
    logic [uart8n1_pkg::BIT_TICKS_W-1:0] period;
    logic [uart8n1_pkg::BIT_TICKS_W-1:0] half_period;
    logic [uart8n1_pkg::BIT_TICKS_W-1:0] tx_cnt_inc;
    logic [uart8n1_pkg::BIT_TICKS_W-1:0] rx_cnt_inc;
    logic [uart8n1_pkg::TIMEOUT_W-1:0]   wait_inc;
    logic [uart8n1_pkg::TX_PHASE_W-1:0]  tx_bit_idx;

    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    assign period      = (bit_ticks_reg == '0) ? uart8n1_pkg::BIT_TICKS_W'(1) : bit_ticks_reg;
    assign half_period = period >> 1;

    always_comb
    begin
        tx_shift_next  = tx_shift_reg;
        tx_phase_next  = tx_phase_reg;
        tx_cnt_next    = tx_cnt_reg;
        rx_phase_next  = rx_phase_reg;
        rx_shift_next  = rx_shift_reg;
        rx_bit_next    = rx_bit_reg;
        rx_cnt_next    = rx_cnt_reg;
        wait_cnt_next  = wait_cnt_reg;

        tx_line_next   = 1'b1;
        tx_active_next = 1'b0;
        rx_valid_next  = 1'b0;
        rx_byte_next   = '0;
        rx_status_next = uart8n1_pkg::RX_STATUS_OK;
        busy_next      = (tx_phase_reg != uart8n1_pkg::TX_IDLE) || (rx_phase_reg != RX_IDLE);

        tx_cnt_inc     = '0;
        rx_cnt_inc     = '0;
        wait_inc       = '0;
        tx_bit_idx     = '0;

        if (!busy_next)
        begin
            if (command == uart8n1_pkg::CMD_SEND)
            begin
                tx_shift_next = tx_byte;
                tx_phase_next = uart8n1_pkg::TX_START;
                tx_cnt_next   = '0;
            end
            else if (command == uart8n1_pkg::CMD_ARM)
            begin
                rx_phase_next = RX_WAIT;
                rx_shift_next = '0;
                rx_bit_next   = '0;
                rx_cnt_next   = '0;
                wait_cnt_next = '0;
            end
        end

        // transmitter
        if (tx_phase_next != uart8n1_pkg::TX_IDLE)
        begin
            tx_bit_idx = tx_phase_next - uart8n1_pkg::TX_FIRST_DATA;
            if (tx_phase_next == uart8n1_pkg::TX_START)
                tx_line_next = 1'b0;
            else if (tx_phase_next <= uart8n1_pkg::TX_LAST_DATA)
                tx_line_next = (tx_bit_idx < uart8n1_pkg::TX_PHASE_W'(uart8n1_pkg::BYTE_W))
                             ? tx_shift_next[tx_bit_idx[2:0]] : 1'b0;
            else
                tx_line_next = 1'b1;
            tx_active_next = (tx_phase_next <= uart8n1_pkg::TX_LAST_DATA);
            tx_cnt_inc = tx_cnt_next + uart8n1_pkg::BIT_TICKS_W'(1);
            if (tx_cnt_inc >= period)
            begin
                tx_cnt_next = '0;
                if (tx_phase_next >= uart8n1_pkg::TX_STOP)
                    tx_phase_next = uart8n1_pkg::TX_IDLE;
                else
                    tx_phase_next = tx_phase_next + uart8n1_pkg::TX_PHASE_W'(1);
            end
            else
            begin
                tx_cnt_next = tx_cnt_inc;
            end
        end

        // receiver
        unique case (rx_phase_next)
            RX_IDLE:
            begin
            end
            RX_WAIT:
            begin
                if (!rx_level)
                begin
                    rx_cnt_next   = '0;
                    rx_bit_next   = '0;
                    rx_phase_next = (half_period == '0) ? RX_SAMPLE : RX_HALF;
                end
                else
                begin
                    wait_inc      = wait_cnt_next + uart8n1_pkg::TIMEOUT_W'(1);
                    wait_cnt_next = wait_inc;
                    if (wait_inc >= rx_timeout_reg)
                    begin
                        rx_valid_next  = 1'b1;
                        rx_status_next = uart8n1_pkg::RX_STATUS_TIMEOUT;
                        rx_phase_next  = RX_IDLE;
                    end
                end
            end
            RX_HALF:
            begin
                rx_cnt_inc = rx_cnt_next + uart8n1_pkg::BIT_TICKS_W'(1);
                if (rx_cnt_inc >= half_period)
                begin
                    rx_cnt_next   = '0;
                    rx_phase_next = RX_SAMPLE;
                end
                else
                begin
                    rx_cnt_next = rx_cnt_inc;
                end
            end
            RX_SAMPLE:
            begin
                rx_cnt_inc = rx_cnt_next + uart8n1_pkg::BIT_TICKS_W'(1);
                if (rx_cnt_inc >= period)
                begin
                    rx_cnt_next = '0;
                    if (rx_bit_next < uart8n1_pkg::RX_BIT_W'(uart8n1_pkg::DATA_BITS))
                    begin
                        if (rx_bit_next < uart8n1_pkg::RX_BIT_W'(uart8n1_pkg::BYTE_W))
                            rx_shift_next[rx_bit_next[2:0]] =
                                rx_shift_next[rx_bit_next[2:0]] | rx_level;
                        rx_bit_next = rx_bit_next + uart8n1_pkg::RX_BIT_W'(1);
                    end
                    else
                    begin
                        rx_valid_next  = 1'b1;
                        rx_byte_next   = rx_shift_next;
                        rx_status_next = rx_level ? uart8n1_pkg::RX_STATUS_OK
                                                  : uart8n1_pkg::RX_STATUS_FRAME;
                        rx_phase_next  = RX_IDLE;
                        rx_bit_next    = '0;
                    end
                end
                else
                begin
                    rx_cnt_next = rx_cnt_inc;
                end
            end
        endcase
    end

    always_comb
    begin
        if (in_fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg  <= uart8n1_pkg::BIT_TICKS_RST;
            rx_timeout_reg <= uart8n1_pkg::RX_TIMEOUT_RST;
            tx_shift_reg   <= '0;
            tx_phase_reg   <= uart8n1_pkg::TX_IDLE;
            tx_cnt_reg     <= '0;
            rx_phase_reg   <= RX_IDLE;
            rx_shift_reg   <= '0;
            rx_bit_reg     <= '0;
            rx_cnt_reg     <= '0;
            wait_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            tx_line_reg    <= 1'b1;
            tx_active_reg  <= 1'b0;
            rx_valid_reg   <= 1'b0;
            rx_byte_reg    <= '0;
            rx_status_reg  <= uart8n1_pkg::RX_STATUS_OK;
            busy_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == uart8n1_pkg::CFG_BIT_TICKS)
                    bit_ticks_reg <= cfg_data[uart8n1_pkg::BIT_TICKS_W-1:0];
                else if (cfg_index == uart8n1_pkg::CFG_RX_TIMEOUT)
                    rx_timeout_reg <= cfg_data[uart8n1_pkg::TIMEOUT_W-1:0];
            end

            out_valid_reg <= out_valid_next;

            if (in_fire)
            begin
                tx_shift_reg  <= tx_shift_next;
                tx_phase_reg  <= tx_phase_next;
                tx_cnt_reg    <= tx_cnt_next;
                rx_phase_reg  <= rx_phase_next;
                rx_shift_reg  <= rx_shift_next;
                rx_bit_reg    <= rx_bit_next;
                rx_cnt_reg    <= rx_cnt_next;
                wait_cnt_reg  <= wait_cnt_next;
                tx_line_reg   <= tx_line_next;
                tx_active_reg <= tx_active_next;
                rx_valid_reg  <= rx_valid_next;
                rx_byte_reg   <= rx_byte_next;
                rx_status_reg <= rx_status_next;
                busy_reg      <= busy_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_line   = tx_line_reg;
    assign tx_active = tx_active_reg;
    assign rx_valid  = rx_valid_reg;
    assign rx_byte   = rx_byte_reg;
    assign rx_status = rx_status_reg;
    assign busy_res  = busy_reg;

    `UART_ASSERT(a_one_engine,
        !((tx_phase_reg != uart8n1_pkg::TX_IDLE) && (rx_phase_reg != RX_IDLE)),
        "tx and rx engines active together")
    `UART_ASSERT(a_tx_phase_range, tx_phase_reg <= uart8n1_pkg::TX_STOP,
        "tx phase past stop bit")
    `UART_ASSERT(a_timeout_byte,
        !(rx_valid_reg && (rx_status_reg == uart8n1_pkg::RX_STATUS_TIMEOUT))
            || (rx_byte_reg == '0),
        "timeout result carries data")
    `UART_ASSERT_NEXT(a_arm_takes,
        in_fire && !busy_next && (command == uart8n1_pkg::CMD_ARM),
        (rx_phase_reg != RX_IDLE) || rx_valid_reg,
        "arm command lost")
    `UART_ASSERT_NEXT(a_send_takes,
        in_fire && !busy_next && (command == uart8n1_pkg::CMD_SEND),
        (tx_phase_reg != uart8n1_pkg::TX_IDLE) && !tx_line_reg,
        "send command did not start frame")

endmodule

@@ verif/uart_8n1_bit_timed_transceiver_tb.sv @@
`timescale 1ns / 1ps

module uart_8n1_bit_timed_transceiver_tb;

    localparam logic [1:0]                          CMD_RSVD     = 2'd3;
    localparam logic [uart8n1_pkg::CFG_INDEX_W-1:0] CFG_RSVD2    = 2'd2;
    localparam logic [uart8n1_pkg::CFG_INDEX_W-1:0] CFG_RSVD3    = 2'd3;
    localparam int                                  RANDOM_TICKS = 1000;
    localparam int                                  PHASE_TICKS  = 140;
    localparam int                                  HOLD_CYCLES  = 60;
    localparam int                                  QUIET_LIMIT  = 5000;

    typedef enum logic [1:0] {RX_OFF, RX_HUNT, RX_HALF, RX_SAMPLE} rx_mode_t;
    typedef enum logic [1:0] {ROW_TICK, ROW_WRITE, ROW_FINISH} row_kind_t;

    typedef struct packed {
        logic                          tx_line;
        logic                          tx_active;
        logic                          rx_valid;
        logic [uart8n1_pkg::BYTE_W-1:0] rx_byte;
        logic [1:0]                    rx_status;
        logic                          busy;
    } uart_tick_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [1:0]                         cmd;
        logic [uart8n1_pkg::BYTE_W-1:0]     data;
        logic                               lvl;
        logic [uart8n1_pkg::CFG_INDEX_W-1:0] reg_idx;
        logic [uart8n1_pkg::CFG_DATA_W-1:0] reg_val;
        logic                               typed;
        uart_tick_t                         want;
    } script_row_t;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_stall;
    logic [1:0]                          command   = uart8n1_pkg::CMD_TICK;
    logic [uart8n1_pkg::BYTE_W-1:0]      tx_byte   = '0;
    logic                                rx_level  = 1'b1;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic                                tx_line;
    logic                                tx_active;
    logic                                rx_valid;
    logic [uart8n1_pkg::BYTE_W-1:0]      rx_byte;
    logic [1:0]                          rx_status;
    logic                                busy_res;
    logic                                cfg_we    = 1'b0;
    logic [uart8n1_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [uart8n1_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // predictor state
    logic [uart8n1_pkg::BIT_TICKS_W-1:0] m_bit_ticks = uart8n1_pkg::BIT_TICKS_RST;
    logic [uart8n1_pkg::TIMEOUT_W-1:0]   m_timeout   = uart8n1_pkg::RX_TIMEOUT_RST;
    logic [uart8n1_pkg::BYTE_W-1:0]      tx_bits     = '0;
    logic [uart8n1_pkg::TX_PHASE_W-1:0]  tx_slot     = uart8n1_pkg::TX_IDLE;
    logic [uart8n1_pkg::BIT_TICKS_W-1:0] tx_count    = '0;
    logic                                tx_level    = 1'b1;
    rx_mode_t                            rx_mode     = RX_OFF;
    logic [uart8n1_pkg::BYTE_W-1:0]      rx_bits     = '0;
    logic [uart8n1_pkg::RX_BIT_W-1:0]    rx_slot     = '0;
    logic [uart8n1_pkg::BIT_TICKS_W-1:0] rx_count    = '0;
    logic [uart8n1_pkg::TIMEOUT_W-1:0]   rx_wait     = '0;

    uart_tick_t  expected_ticks[$];
    script_row_t script[$];

    int  errors       = 0;
    int  ticks_sent   = 0;
    int  results_seen = 0;
    int  n_sends      = 0;
    int  n_ok         = 0;
    int  n_framing    = 0;
    int  n_timeouts   = 0;
    int  n_settings   = 0;
    bit  no_idle      = 1'b0;
    bit  want_hold    = 1'b0;
    bit  hold_done    = 1'b0;

    uart_8n1_bit_timed_transceiver u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .tx_byte   (tx_byte),
        .rx_level  (rx_level),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tx_line   (tx_line),
        .tx_active (tx_active),
        .rx_valid  (rx_valid),
        .rx_byte   (rx_byte),
        .rx_status (rx_status),
        .busy_res  (busy_res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit engine_busy();
        return (tx_slot != uart8n1_pkg::TX_IDLE) || (rx_mode != RX_OFF);
    endfunction

    function automatic logic [1:0] noise_cmd();
        return ($urandom_range(99) < 20) ? 2'($urandom) : uart8n1_pkg::CMD_TICK;
    endfunction

    function automatic uart_tick_t tick_result(input logic line, input logic act,
                                               input logic v,
                                               input logic [uart8n1_pkg::BYTE_W-1:0] b,
                                               input logic [1:0] st, input logic bsy);
        return {line, act, v, b, st, bsy};
    endfunction

    function automatic string show(input uart_tick_t t);
        return $sformatf("line %b act %b valid %b byte %02h status %0d busy %b",
                         t.tx_line, t.tx_active, t.rx_valid, t.rx_byte, t.rx_status, t.busy);
    endfunction

    // one tick of the transceiver: command, transmitter, then receiver
    function automatic uart_tick_t advance_uart(input logic [1:0] cmd,
                                                input logic [uart8n1_pkg::BYTE_W-1:0] data,
                                                input logic lvl);
        uart_tick_t                         r;
        int                                 per;
        logic [uart8n1_pkg::TX_PHASE_W-1:0] idx;
        r   = '0;
        per = (m_bit_ticks == 0) ? 1 : int'(m_bit_ticks);
        r.busy = engine_busy();
        if (!r.busy)
        begin
            if (cmd == uart8n1_pkg::CMD_SEND)
            begin
                tx_bits  = data;
                tx_slot  = uart8n1_pkg::TX_START;
                tx_count = '0;
                n_sends++;
            end
            else if (cmd == uart8n1_pkg::CMD_ARM)
            begin
                rx_mode  = RX_HUNT;
                rx_bits  = '0;
                rx_slot  = '0;
                rx_count = '0;
                rx_wait  = '0;
            end
        end

        if (tx_slot != uart8n1_pkg::TX_IDLE)
        begin
            idx = tx_slot - uart8n1_pkg::TX_FIRST_DATA;
            if (tx_slot == uart8n1_pkg::TX_START)
                tx_level = 1'b0;
            else if (tx_slot <= uart8n1_pkg::TX_LAST_DATA)
                tx_level = (idx < uart8n1_pkg::BYTE_W) ? tx_bits[idx] : 1'b0;
            else
                tx_level = 1'b1;
            r.tx_active = (tx_slot <= uart8n1_pkg::TX_LAST_DATA);
            tx_count = tx_count + 1'b1;
            if (tx_count >= per)
            begin
                tx_count = '0;
                tx_slot  = (tx_slot == uart8n1_pkg::TX_STOP) ? uart8n1_pkg::TX_IDLE
                                                             : tx_slot + 1'b1;
            end
        end
        else
        begin
            tx_level = 1'b1;
        end

        unique case (rx_mode)
            RX_OFF: ;
            RX_HUNT:
            begin
                if (!lvl)
                begin
                    rx_count = '0;
                    rx_slot  = '0;
                    rx_mode  = (per / 2 == 0) ? RX_SAMPLE : RX_HALF;
                end
                else
                begin
                    rx_wait = rx_wait + 1'b1;
                    if (rx_wait >= m_timeout)
                    begin
                        r.rx_valid  = 1'b1;
                        r.rx_status = uart8n1_pkg::RX_STATUS_TIMEOUT;
                        rx_mode     = RX_OFF;
                    end
                end
            end
            RX_HALF:
            begin
                rx_count = rx_count + 1'b1;
                if (rx_count >= per / 2)
                begin
                    rx_count = '0;
                    rx_mode  = RX_SAMPLE;
                end
            end
            RX_SAMPLE:
            begin
                rx_count = rx_count + 1'b1;
                if (rx_count >= per)
                begin
                    rx_count = '0;
                    if (rx_slot < uart8n1_pkg::DATA_BITS)
                    begin
                        if (rx_slot < uart8n1_pkg::BYTE_W)
                            rx_bits = rx_bits | (8'(lvl) << rx_slot);
                        rx_slot = rx_slot + 1'b1;
                    end
                    else
                    begin
                        r.rx_valid  = 1'b1;
                        r.rx_byte   = rx_bits;
                        r.rx_status = lvl ? uart8n1_pkg::RX_STATUS_OK
                                          : uart8n1_pkg::RX_STATUS_FRAME;
                        rx_mode     = RX_OFF;
                        rx_slot     = '0;
                    end
                end
            end
        endcase

        r.tx_line = tx_level;
        return r;
    endfunction

    function automatic script_row_t tick_row(input logic [1:0] cmd,
                                             input logic [uart8n1_pkg::BYTE_W-1:0] data,
                                             input logic lvl);
        script_row_t row;
        row      = '0;
        row.kind = ROW_TICK;
        row.cmd  = cmd;
        row.data = data;
        row.lvl  = lvl;
        return row;
    endfunction

    function automatic script_row_t checked_row(input logic [1:0] cmd,
                                                input logic [uart8n1_pkg::BYTE_W-1:0] data,
                                                input logic lvl, input uart_tick_t want);
        script_row_t row;
        row       = tick_row(cmd, data, lvl);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic script_row_t write_row(input logic [uart8n1_pkg::CFG_INDEX_W-1:0] idx,
                                              input logic [uart8n1_pkg::CFG_DATA_W-1:0] val);
        script_row_t row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic script_row_t finish_row(input logic lvl);
        script_row_t row;
        row      = '0;
        row.kind = ROW_FINISH;
        row.lvl  = lvl;
        return row;
    endfunction

    task automatic drive_tick(input logic [1:0] cmd,
                              input logic [uart8n1_pkg::BYTE_W-1:0] data,
                              input logic lvl, input bit typed = 1'b0,
                              input uart_tick_t want = '0);
        uart_tick_t predicted;
        while (!no_idle && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        tx_byte  <= data;
        rx_level <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = advance_uart(cmd, data, lvl);
        expected_ticks.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    // registers change only with no beat in flight
    task automatic write_reg(input logic [uart8n1_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [uart8n1_pkg::CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        unique case (idx)
            uart8n1_pkg::CFG_BIT_TICKS:  m_bit_ticks = val[uart8n1_pkg::BIT_TICKS_W-1:0];
            uart8n1_pkg::CFG_RX_TIMEOUT: m_timeout   = val;
            default: ;
        endcase
        n_settings++;
    endtask

    // result side: random stall, plus one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (want_hold && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                out_stall <= !no_idle && ($urandom_range(99) < 35);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        uart_tick_t seen;
        uart_tick_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {tx_line, tx_active, rx_valid, rx_byte, rx_status, busy_res};
            if (expected_ticks.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: %s", show(seen));
            end
            else
            begin
                want = expected_ticks.pop_front();
                results_seen++;
                if (seen !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("beat %0d: expected %s, got %s",
                                 results_seen, show(want), show(seen));
                end
                if (want.rx_valid)
                begin
                    unique case (want.rx_status)
                        uart8n1_pkg::RX_STATUS_OK:      n_ok++;
                        uart8n1_pkg::RX_STATUS_FRAME:   n_framing++;
                        uart8n1_pkg::RX_STATUS_TIMEOUT: n_timeouts++;
                        default: ;
                    endcase
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("uart_8n1_bit_timed_transceiver_tb failed");
        $finish;
    end

    initial
    begin : stimulus
        int                                  phase_no;
        int                                  phase_end;
        int                                  pick;
        int                                  n_high;
        int                                  per_ticks;
        int                                  bit_no;
        int                                  directed_ticks;
        logic [1:0]                          cmd_next;
        logic [uart8n1_pkg::BYTE_W-1:0]      frame;
        logic                                stop_ok;
        logic                                lv;
        logic [uart8n1_pkg::BIT_TICKS_W-1:0] bt;
        logic [uart8n1_pkg::TIMEOUT_W-1:0]   to;

        // after reset, unknown command and register, tiny period, timeouts,
        // extremes, and register changes while an engine runs
        script.push_back(checked_row(uart8n1_pkg::CMD_TICK, 8'h00, 1'b1,
            tick_result(1'b1, 1'b0, 1'b0, 8'h00, uart8n1_pkg::RX_STATUS_OK, 1'b0)));
        script.push_back(checked_row(CMD_RSVD, 8'hFF, 1'b0,
            tick_result(1'b1, 1'b0, 1'b0, 8'h00, uart8n1_pkg::RX_STATUS_OK, 1'b0)));
        script.push_back(write_row(CFG_RSVD2, 32'hFFFF_FFFF));
        script.push_back(write_row(CFG_RSVD3, 32'h0000_0000));
        script.push_back(write_row(uart8n1_pkg::CFG_BIT_TICKS, 32'hFFFF_0000));
        script.push_back(checked_row(uart8n1_pkg::CMD_SEND, 8'hFF, 1'b1,
            tick_result(1'b0, 1'b1, 1'b0, 8'h00, uart8n1_pkg::RX_STATUS_OK, 1'b0)));
        script.push_back(checked_row(uart8n1_pkg::CMD_ARM, 8'h00, 1'b0,
            tick_result(1'b1, 1'b1, 1'b0, 8'h00, uart8n1_pkg::RX_STATUS_OK, 1'b1)));
        script.push_back(finish_row(1'b1));
        script.push_back(write_row(uart8n1_pkg::CFG_RX_TIMEOUT, 32'd0));
        script.push_back(checked_row(uart8n1_pkg::CMD_ARM, 8'h00, 1'b1,
            tick_result(1'b1, 1'b0, 1'b1, 8'h00, uart8n1_pkg::RX_STATUS_TIMEOUT, 1'b0)));
        script.push_back(write_row(uart8n1_pkg::CFG_RX_TIMEOUT, 32'd1));
        script.push_back(checked_row(uart8n1_pkg::CMD_ARM, 8'h5A, 1'b1,
            tick_result(1'b1, 1'b0, 1'b1, 8'h00, uart8n1_pkg::RX_STATUS_TIMEOUT, 1'b0)));
        script.push_back(write_row(uart8n1_pkg::CFG_BIT_TICKS, 32'd1));
        script.push_back(write_row(uart8n1_pkg::CFG_RX_TIMEOUT, 32'hFFFF_FFFF));
        script.push_back(tick_row(uart8n1_pkg::CMD_ARM, 8'h00, 1'b0));
        script.push_back(finish_row(1'b0));
        script.push_back(write_row(uart8n1_pkg::CFG_BIT_TICKS, 32'd65535));
        script.push_back(checked_row(uart8n1_pkg::CMD_SEND, 8'h00, 1'b1,
            tick_result(1'b0, 1'b1, 1'b0, 8'h00, uart8n1_pkg::RX_STATUS_OK, 1'b0)));
        script.push_back(tick_row(uart8n1_pkg::CMD_TICK, 8'h00, 1'b1));
        script.push_back(tick_row(uart8n1_pkg::CMD_TICK, 8'h00, 1'b1));
        script.push_back(write_row(uart8n1_pkg::CFG_BIT_TICKS, 32'd2));
        script.push_back(finish_row(1'b1));
        script.push_back(tick_row(uart8n1_pkg::CMD_ARM, 8'h00, 1'b1));
        script.push_back(tick_row(uart8n1_pkg::CMD_TICK, 8'h00, 1'b1));
        script.push_back(write_row(uart8n1_pkg::CFG_RX_TIMEOUT, 32'd3));
        script.push_back(checked_row(uart8n1_pkg::CMD_TICK, 8'h00, 1'b1,
            tick_result(1'b1, 1'b0, 1'b1, 8'h00, uart8n1_pkg::RX_STATUS_TIMEOUT, 1'b1)));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            unique case (script[i].kind)
                ROW_WRITE:  write_reg(script[i].reg_idx, script[i].reg_val);
                ROW_FINISH:
                begin
                    while (engine_busy())
                        drive_tick(uart8n1_pkg::CMD_TICK, 8'h00, script[i].lvl);
                end
                default:
                begin
                    drive_tick(script[i].cmd, script[i].data, script[i].lvl,
                               script[i].typed, script[i].want);
                end
            endcase
        end
        directed_ticks = ticks_sent;

        phase_no = 0;
        while (ticks_sent < directed_ticks + RANDOM_TICKS)
        begin
            unique case (phase_no % 8)
                0:
                begin
                    bt = 16'd2;
                    to = 32'd1;
                end
                1:
                begin
                    bt = 16'd1;
                    to = 32'd0;
                end
                2:
                begin
                    bt = 16'($urandom_range(2, 6));
                    to = $urandom_range(2, 30);
                end
                3:
                begin
                    bt = 16'd0;
                    to = 32'hFFFF_FFFF;
                end
                4:
                begin
                    bt = 16'($urandom_range(3, 5));
                    to = $urandom;
                end
                5:
                begin
                    bt = 16'($urandom_range(7, 12));
                    to = $urandom_range(1, 60);
                end
                default:
                begin
                    bt = 16'($urandom_range(2, 6));
                    to = $urandom_range(1, 40);
                end
            endcase
            write_reg(uart8n1_pkg::CFG_BIT_TICKS, {16'($urandom), bt});
            write_reg(uart8n1_pkg::CFG_RX_TIMEOUT, to);
            if ($urandom_range(1))
                write_reg($urandom_range(1) ? CFG_RSVD2 : CFG_RSVD3, $urandom);
            want_hold = (phase_no == 2);
            no_idle   = (phase_no == 4);
            per_ticks = (m_bit_ticks == 0) ? 1 : int'(m_bit_ticks);
            phase_end = ticks_sent + PHASE_TICKS;

            while (ticks_sent < phase_end)
            begin
                while (engine_busy())
                    drive_tick(2'($urandom), 8'($urandom), 1'($urandom));
                pick = $urandom_range(99);
                if (pick < 35)
                begin
                    drive_tick(uart8n1_pkg::CMD_SEND, 8'($urandom), 1'($urandom));
                end
                else if (pick < 75)
                begin
                    // armed receiver fed a frame at the current bit period, stop bit sometimes low
                    frame    = 8'($urandom);
                    stop_ok  = ($urandom_range(99) < 85);
                    n_high   = (m_timeout == 0) ? 0 :
                               $urandom_range(0, (m_timeout > 6) ? 5 : m_timeout - 1);
                    cmd_next = uart8n1_pkg::CMD_ARM;
                    repeat (n_high)
                    begin
                        drive_tick(cmd_next, 8'($urandom), 1'b1);
                        cmd_next = noise_cmd();
                    end
                    for (bit_no = 0; bit_no < uart8n1_pkg::DATA_BITS + 2; bit_no++)
                    begin
                        if (bit_no == 0)
                            lv = 1'b0;
                        else if (bit_no == uart8n1_pkg::DATA_BITS + 1)
                            lv = stop_ok;
                        else
                            lv = (bit_no - 1 < uart8n1_pkg::BYTE_W) ? frame[bit_no-1] : 1'b0;
                        repeat (per_ticks)
                        begin
                            drive_tick(cmd_next, 8'($urandom), lv);
                            cmd_next = noise_cmd();
                        end
                    end
                end
                else if (pick < 85 && m_timeout <= 60)
                begin
                    drive_tick(uart8n1_pkg::CMD_ARM, 8'($urandom), 1'b1);
                    while (engine_busy())
                        drive_tick(noise_cmd(), 8'($urandom), 1'b1);
                end
                else
                begin
                    repeat ($urandom_range(1, 8))
                        drive_tick(2'($urandom), 8'($urandom), 1'($urandom));
                end
            end
            phase_no++;
        end

        in_valid <= 1'b0;
        no_idle = 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("%0d ticks over %0d register writes, %0d bytes sent", ticks_sent,
                 n_settings, n_sends);
        $display("receives: %0d clean, %0d framing errors, %0d start timeouts; %0d mismatches",
                 n_ok, n_framing, n_timeouts, errors);
        if (errors == 0 && expected_ticks.size() == 0)
            $display("uart_8n1_bit_timed_transceiver_tb passed");
        else
            $display("uart_8n1_bit_timed_transceiver_tb failed");
        $finish;
    end

endmodule
